### src/adrc_pkg.sv
// Shared types and constants of the audio dynamic range compressor.
`default_nettype none
package adrc_pkg;

  localparam int MS_FRAC = 46;
  localparam logic [18:0] K_AMP = 19'd394566;
  localparam logic [18:0] K_POW = 19'd197283;
  localparam logic [16:0] GAIN_FLOOR_MAG = 17'd65536;

  localparam logic [3:0] REG_DETECTOR_MODE   = 4'd0;
  localparam logic [3:0] REG_THRESHOLD_LEVEL = 4'd1;
  localparam logic [3:0] REG_RATIO_RECIP     = 4'd2;
  localparam logic [3:0] REG_KNEE_WIDTH      = 4'd3;
  localparam logic [3:0] REG_KNEE_HALF_RECIP = 4'd4;
  localparam logic [3:0] REG_ATTACK_COEFF    = 4'd5;
  localparam logic [3:0] REG_RELEASE_COEFF   = 4'd6;
  localparam logic [3:0] REG_RMS_COEFF       = 4'd7;

  typedef struct packed {
    logic               detector_mode;
    logic signed [15:0] threshold_level;
    logic [16:0]        ratio_recip;
    logic [12:0]        knee_width;
    logic [22:0]        knee_half_recip;
  } adrc_cfg_t;

  typedef enum logic [18:0] {
    S_IDLE  = 19'b0000000000000000001,
    S_SQL   = 19'b0000000000000000010,
    S_SQR   = 19'b0000000000000000100,
    S_RMS0  = 19'b0000000000000001000,
    S_RMS1  = 19'b0000000000000010000,
    S_RMS2  = 19'b0000000000000100000,
    S_RMS3  = 19'b0000000000001000000,
    S_RMS4  = 19'b0000000000010000000,
    S_NORM  = 19'b0000000000100000000,
    S_LOGSQ = 19'b0000000001000000000,
    S_DB    = 19'b0000000010000000000,
    S_GAIN  = 19'b0000000100000000000,
    S_KNEE0 = 19'b0000001000000000000,
    S_KNEE1 = 19'b0000010000000000000,
    S_KNEE2 = 19'b0000100000000000000,
    S_KNEE3 = 19'b0001000000000000000,
    S_ENV0  = 19'b0010000000000000000,
    S_ENV1  = 19'b0100000000000000000,
    S_SPARE = 19'b1000000000000000000
  } adrc_state_e;

endpackage
`default_nettype wire

### src/adrc_front.sv
// Input side: takes sample pairs, forms magnitudes and peak, and queues them.
`default_nettype none
module adrc_front #(
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic signed [SAMPLE_BITS-1:0] left_sample_i,
  input  wire logic signed [SAMPLE_BITS-1:0] right_sample_i,
  output logic                               q_valid_o,
  input  wire logic                          q_pop_i,
  output logic [SAMPLE_BITS-1:0]             q_al_o,
  output logic [SAMPLE_BITS-1:0]             q_ar_o,
  output logic [SAMPLE_BITS-1:0]             q_peak_o
);

  logic [SAMPLE_BITS-1:0] al, ar;
  logic [SAMPLE_BITS-1:0] al_mem [2];
  logic [SAMPLE_BITS-1:0] ar_mem [2];
  logic [SAMPLE_BITS-1:0] pk_mem [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  // Magnitudes are unsigned so the most negative sample still fits.
  assign al = left_sample_i[SAMPLE_BITS-1] ? (~left_sample_i) + 1'b1 : left_sample_i;
  assign ar = right_sample_i[SAMPLE_BITS-1] ? (~right_sample_i) + 1'b1 : right_sample_i;

  assign full      = (cnt_q == 2'd2);
  assign q_valid_o = (cnt_q != 2'd0);
  assign do_push   = push && !full;
  assign do_pop    = q_pop_i && q_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      al_mem[wr_ptr_q] <= al;
      ar_mem[wr_ptr_q] <= ar;
      pk_mem[wr_ptr_q] <= (al > ar) ? al : ar;
    end
  end

  assign q_al_o   = al_mem[rd_ptr_q];
  assign q_ar_o   = ar_mem[rd_ptr_q];
  assign q_peak_o = pk_mem[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule
`default_nettype wire

### src/adrc_back.sv
// Processing side: detector, log conversion, gain curve and envelope sequencer.
`default_nettype none
module adrc_back
  import adrc_pkg::*;
#(
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_BITS   = 24
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire adrc_cfg_t              cfg_i,
  input  wire logic [COEF_BITS-1:0]   attack_coeff_i,
  input  wire logic [COEF_BITS-1:0]   release_coeff_i,
  input  wire logic [COEF_BITS-1:0]   rms_coeff_i,
  input  wire logic                   clear_avg_i,
  input  wire logic                   q_valid_i,
  output logic                        q_pop_o,
  input  wire logic [SAMPLE_BITS-1:0] q_al_i,
  input  wire logic [SAMPLE_BITS-1:0] q_ar_i,
  input  wire logic [SAMPLE_BITS-1:0] q_peak_i,
  output logic                        empty,
  input  wire logic                   pop,
  output logic signed [16:0]          gain_level_o
);

  localparam int ACC_W = COEF_BITS + 49;
  localparam int SQ_W  = 2 * SAMPLE_BITS + 1;
  localparam int SH    = 2 * (SAMPLE_BITS - 1) - MS_FRAC;
  localparam logic [COEF_BITS:0] ONE = {1'b1, {COEF_BITS{1'b0}}};

  adrc_state_e state_q;
  logic [SAMPLE_BITS-1:0] al_q, ar_q;
  logic [SQ_W-1:0]   sq_q;
  logic [46:0]       ms_q;
  logic [47:0]       avg_q, x_q;
  logic [ACC_W-1:0]  acc_q;
  logic [5:0]        msb_q;
  logic [31:0]       mant_q;
  logic [15:0]       frac_q;
  logic [3:0]        cnt_q;
  logic signed [17:0] lev_q;
  logic [16:0]       redm_q;
  logic [14:0]       e_q;
  logic [29:0]       ee_q;
  logic [52:0]       eh_q;
  logic [69:0]       kp_q;
  logic [COEF_BITS-1:0] c_q;
  logic [31:0]       env_q;
  logic              out_valid_q;
  logic signed [16:0] gain_q;

  logic [SQ_W-1:0]   sq_sum;
  logic [63:0]       sq_wide, ms_wide;
  logic [63:0]       mant_sq;
  logic [32:0]       mant_t;
  logic [21:0]       log_l, log_full, log_neg;
  logic [40:0]       db_prod;
  logic signed [18:0] d_val;
  logic signed [19:0] two_d, w_s;
  logic [16:0]       s_val;
  logic [34:0]       hard_prod;
  logic [18:0]       hard_red;
  logic [69:0]       knee_total;
  logic [27:0]       knee_red;
  logic [24:0]       m_val;
  logic [COEF_BITS-1:0] c_sel;
  logic [ACC_W-1:0]  env_sum;
  logic [31:0]       env_new;
  logic [47:0]       avg_new;
  logic              out_free;

  assign q_pop_o  = (state_q == S_IDLE) && q_valid_i;
  assign out_free = !out_valid_q || pop;
  assign empty    = !out_valid_q;
  assign gain_level_o = gain_q;

  // Mean square of the pair, rescaled to 46 fraction bits.
  assign sq_sum  = sq_q + SQ_W'(ar_q * ar_q);
  assign sq_wide = 64'(sq_sum >> 1);
  assign ms_wide = (SH >= 0) ? (sq_wide >> SH) : (sq_wide << (-SH));

  assign mant_sq = mant_q * mant_q;
  assign mant_t  = mant_sq[63:31];

  assign log_l    = {msb_q, frac_q};
  assign log_full = cfg_i.detector_mode ? 22'(MS_FRAC << 16) : 22'((SAMPLE_BITS - 1) << 16);
  assign log_neg  = (log_full > log_l) ? (log_full - log_l) : 22'd0;
  assign db_prod  = log_neg * (cfg_i.detector_mode ? K_POW : K_AMP);

  assign d_val = 19'(lev_q) - 19'(cfg_i.threshold_level);
  assign two_d = 20'(d_val) <<< 1;
  assign w_s   = $signed({7'd0, cfg_i.knee_width});
  assign s_val = 17'(18'd65536 - ((cfg_i.ratio_recip > 17'd65536) ? 18'd65536
                                                                 : {1'b0, cfg_i.ratio_recip}));
  assign hard_prod = d_val[17:0] * s_val;
  assign hard_red  = hard_prod[34:16];

  assign knee_total = kp_q + ({49'd0, eh_q[52:32]} * 70'(s_val) << 32);
  assign knee_red   = knee_total[69:42];

  assign m_val   = {redm_q, 8'd0};
  assign c_sel   = (32'(m_val) > env_q) ? attack_coeff_i : release_coeff_i;
  assign env_sum = acc_q + ACC_W'((ONE - {1'b0, c_q}) * m_val);
  assign env_new = env_sum[COEF_BITS+31:COEF_BITS];
  assign avg_new = acc_q[COEF_BITS+47:COEF_BITS];

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        al_q   <= q_al_i;
        ar_q   <= q_ar_i;
        x_q    <= (q_peak_i == '0) ? 48'd1 : 48'(q_peak_i);
        msb_q  <= 6'd47;
        frac_q <= 16'd0;
      end
      S_SQL: sq_q <= SQ_W'(al_q * al_q);
      S_SQR: ms_q <= ms_wide[46:0];
      S_RMS0: acc_q <= ACC_W'(rms_coeff_i * avg_q[23:0]);
      S_RMS1: acc_q <= acc_q + (ACC_W'(rms_coeff_i * avg_q[47:24]) << 24);
      S_RMS2: acc_q <= acc_q + ACC_W'((ONE - {1'b0, rms_coeff_i}) * ms_q[23:0]);
      S_RMS3: acc_q <= acc_q + (ACC_W'((ONE - {1'b0, rms_coeff_i}) * ms_q[46:24]) << 24);
      S_RMS4: x_q <= (avg_new == '0) ? 48'd1 : avg_new;
      S_NORM: begin
        if (x_q[47]) begin
          mant_q <= x_q[47:16];
          cnt_q  <= 4'd0;
        end else if (x_q[47:40] == 8'd0) begin
          x_q   <= x_q << 8;
          msb_q <= msb_q - 6'd8;
        end else begin
          x_q   <= x_q << 1;
          msb_q <= msb_q - 6'd1;
        end
      end
      S_LOGSQ: begin
        frac_q <= {frac_q[14:0], mant_t[32]};
        mant_q <= mant_t[32] ? mant_t[32:1] : mant_t[31:0];
        cnt_q  <= cnt_q + 4'd1;
      end
      S_DB: lev_q <= -$signed({1'b0, db_prod[40:24]});
      S_GAIN: begin
        // Above the knee (or with a hard knee) the reduction is linear in the overshoot.
        redm_q <= ((cfg_i.knee_width == 13'd0 || two_d > w_s) && d_val > 0)
                  ? ((hard_red > 19'(GAIN_FLOOR_MAG)) ? GAIN_FLOOR_MAG : hard_red[16:0])
                  : 17'd0;
        e_q <= 15'(two_d + w_s);
      end
      S_KNEE0: ee_q <= e_q * e_q;
      S_KNEE1: eh_q <= ee_q * cfg_i.knee_half_recip;
      S_KNEE2: kp_q <= 70'(eh_q[31:0] * s_val);
      S_KNEE3: redm_q <= (knee_red > 28'(GAIN_FLOOR_MAG)) ? GAIN_FLOOR_MAG : knee_red[16:0];
      S_ENV0: begin
        c_q   <= c_sel;
        acc_q <= ACC_W'(c_sel * env_q);
      end
      S_ENV1: begin
        if (out_free) begin
          gain_q <= $signed(17'(17'd0 - env_new[24:8]));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      avg_q       <= 48'd0;
      env_q       <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_ENV1 && out_free) out_valid_q <= 1'b1;
      else if (pop && out_valid_q) out_valid_q <= 1'b0;
      if (clear_avg_i) avg_q <= 48'd0;
      else if (state_q == S_RMS4) avg_q <= avg_new;
      case (state_q)
        S_IDLE:  if (q_valid_i) state_q <= cfg_i.detector_mode ? S_SQL : S_NORM;
        S_SQL:   state_q <= S_SQR;
        S_SQR:   state_q <= S_RMS0;
        S_RMS0:  state_q <= S_RMS1;
        S_RMS1:  state_q <= S_RMS2;
        S_RMS2:  state_q <= S_RMS3;
        S_RMS3:  state_q <= S_RMS4;
        S_RMS4:  state_q <= S_NORM;
        S_NORM:  if (x_q[47]) state_q <= S_LOGSQ;
        S_LOGSQ: if (cnt_q == 4'd15) state_q <= S_DB;
        S_DB:    state_q <= S_GAIN;
        S_GAIN: begin
          if (cfg_i.knee_width == 13'd0 || two_d > w_s || two_d <= -w_s) begin
            state_q <= S_ENV0;
          end else begin
            state_q <= S_KNEE0;
          end
        end
        S_KNEE0: state_q <= S_KNEE1;
        S_KNEE1: state_q <= S_KNEE2;
        S_KNEE2: state_q <= S_KNEE3;
        S_KNEE3: state_q <= S_ENV0;
        S_ENV0:  state_q <= S_ENV1;
        S_ENV1: begin
          if (out_free) begin
            env_q   <= env_new;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // A waiting result is never dropped before it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !pop |=> out_valid_q)
    else $error("result dropped while waiting");

  // A published gain is never a boost.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> gain_q <= 0)
    else $error("gain level above zero");

  // A queued item always starts either the RMS path or the log stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> (state_q == S_SQL) || (state_q == S_NORM))
    else $error("item popped without starting work");

endmodule
`default_nettype wire

### src/audio_dynamic_range_compressor_top.sv
// Top level of the audio dynamic range compressor gain computer.
`default_nettype none
// Feed-forward compressor gain computer for stereo Q1.(SAMPLE_BITS-1) samples.
// Each pair pushed in yields one item on the result side: the smoothed gain
// reduction in 1/256 dB, between -65536 and 0. A two-entry input queue lets
// up to two pairs wait while one is being processed. Processing is done by a
// sequencer whose time per item is set mainly by the sixteen squaring steps of
// the log2 unit and the leading-one search (eight bit positions a step, then
// one); RMS mode adds the squares and the averaging multiplies, and a soft
// knee region adds the knee steps. The last step waits while the previous
// result has not been taken.
// The configuration port is always ready; write it only while no item is in
// flight. A write of the detector mode that changes it clears the RMS average.
module audio_dynamic_range_compressor_top
  import adrc_pkg::*;
#(
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_BITS   = 24
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic signed [SAMPLE_BITS-1:0] left_sample_i,
  input  wire logic signed [SAMPLE_BITS-1:0] right_sample_i,
  output logic                               empty,
  input  wire logic                          pop,
  output logic signed [16:0]                 gain_level_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [3:0]                    cfg_index_i,
  input  wire logic [31:0]                   cfg_data_i
);

  adrc_cfg_t cfg_q;
  logic [COEF_BITS-1:0] attack_q, release_q, rms_q;
  logic cfg_we, clear_avg;
  logic q_valid, q_pop;
  logic [SAMPLE_BITS-1:0] q_al, q_ar, q_peak;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;
  // Only a real change of detector mode discards the running average.
  assign clear_avg   = cfg_we && (cfg_index_i == REG_DETECTOR_MODE) &&
                       (cfg_data_i[0] != cfg_q.detector_mode);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.detector_mode   <= 1'b0;
      cfg_q.threshold_level <= -16'sd5120;
      cfg_q.ratio_recip     <= 17'd16384;
      cfg_q.knee_width      <= 13'd0;
      cfg_q.knee_half_recip <= 23'd0;
      attack_q              <= COEF_BITS'(24'd16773000);
      release_q             <= COEF_BITS'(24'd16776000);
      rms_q                 <= COEF_BITS'(24'd16742000);
    end else if (cfg_we) begin
      case (cfg_index_i)
        REG_DETECTOR_MODE:   cfg_q.detector_mode   <= cfg_data_i[0];
        REG_THRESHOLD_LEVEL: cfg_q.threshold_level <= $signed(cfg_data_i[15:0]);
        REG_RATIO_RECIP:     cfg_q.ratio_recip     <= cfg_data_i[16:0];
        REG_KNEE_WIDTH:      cfg_q.knee_width      <= cfg_data_i[12:0];
        REG_KNEE_HALF_RECIP: cfg_q.knee_half_recip <= cfg_data_i[22:0];
        REG_ATTACK_COEFF:    attack_q              <= cfg_data_i[COEF_BITS-1:0];
        REG_RELEASE_COEFF:   release_q             <= cfg_data_i[COEF_BITS-1:0];
        REG_RMS_COEFF:       rms_q                 <= cfg_data_i[COEF_BITS-1:0];
        default: ;
      endcase
    end
  end

  adrc_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .left_sample_i (left_sample_i),
    .right_sample_i(right_sample_i),
    .q_valid_o     (q_valid),
    .q_pop_i       (q_pop),
    .q_al_o        (q_al),
    .q_ar_o        (q_ar),
    .q_peak_o      (q_peak)
  );

  adrc_back #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COEF_BITS  (COEF_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .attack_coeff_i (attack_q),
    .release_coeff_i(release_q),
    .rms_coeff_i    (rms_q),
    .clear_avg_i    (clear_avg),
    .q_valid_i      (q_valid),
    .q_pop_o        (q_pop),
    .q_al_i         (q_al),
    .q_ar_i         (q_ar),
    .q_peak_i       (q_peak),
    .empty          (empty),
    .pop            (pop),
    .gain_level_o   (gain_level_o)
  );

endmodule
`default_nettype wire
